// File: rtl/brc_pkg.sv
// Shared types and constants for the bump and boundary recovery block.
// Used by brc_cfg, brc_core and the top level; no dependencies.
package brc_pkg;

	// Default width of the maneuver timer
	localparam int TIMER_BITS_DEF = 16;

	// Input command codes
	localparam logic [1:0] CMD_BUMP = 2'd0;
	localparam logic [1:0] CMD_EDGE = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	// Configuration register indexes
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_ADDR_W-1:0] REG_ENABLE_MASK     = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_ATTEMPTS    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_BUMP_REVERSE_MS = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_BUMP_ROTATE_MS  = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_EDGE_REVERSE_MS = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_EDGE_ROTATE_MS  = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_BACK_SPEED      = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_TURN_SPEED      = 3'd7;

	// Widths of the packed stream words
	localparam int IN_DATA_W  = 8;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 40;

	// Maneuver phase
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_REVERSE = 2'd1,
		PH_ROTATE  = 2'd2
	} phase_t;

	// Configuration register file contents
	typedef struct packed {
		logic [1:0]  enable_mask;
		logic [3:0]  max_attempts;
		logic [15:0] bump_reverse_ms;
		logic [15:0] bump_rotate_ms;
		logic [15:0] edge_reverse_ms;
		logic [15:0] edge_rotate_ms;
		logic [14:0] back_speed;
		logic [14:0] turn_speed;
	} cfg_t;

	// One result word
	typedef struct packed {
		logic               source_channel;
		logic               emergency_stop;
		logic signed [15:0] angular_speed;
		logic signed [15:0] linear_speed;
		logic               drive_valid;
	} res_t;

endpackage

// File: rtl/bump_and_boundary_recovery_fsm.sv
// Bump and boundary recovery controller, top level.
// Path from input accept to result accept: input stage, then result register.
// Throughput: one word per cycle while m_tready is high; the input stage and result register each hold one word.
// One result word for every input word; stalls on m_tready propagate to s_tready.
// Reset (arst_n low, asynchronous): both stages empty, state cleared, registers to defaults.
// Depends on brc_pkg, brc_cfg, brc_core.
module bump_and_boundary_recovery_fsm #(
	parameter int TIMER_BITS = brc_pkg::TIMER_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [brc_pkg::IN_DATA_W-1:0]    s_tdata,   // [0] left_flag, [1] right_flag
	input  logic [brc_pkg::IN_USER_W-1:0]    s_tuser,   // [1:0] cmd
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [0] drive_valid, [16:1] linear_speed, [32:17] angular_speed,
	// [33] emergency_stop, [34] source_channel
	output logic [brc_pkg::OUT_DATA_W-1:0]   m_tdata,
	// configuration
	input  logic                             cfg_we,
	input  logic [brc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [brc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import brc_pkg::*;

	cfg_t cfg;
	res_t res;

	logic       s1_valid_q;
	logic [1:0] cmd_s1;
	logic       left_s1;
	logic       right_s1;
	logic       out_valid_q;
	res_t       out_q;
	logic       adv;
	logic       s_accept;

	brc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	brc_core #(
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.cmd        (cmd_s1),
		.left_flag  (left_s1),
		.right_flag (right_s1),
		.cfg        (cfg),
		.res        (res)
	);

	// Handshake: input stage moves on when the result register is free or draining
	assign adv      = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || adv;
	assign s_accept = s_tvalid && s_tready;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_accept) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1   <= s_tuser[1:0];
			left_s1  <= s_tdata[0];
			right_s1 <= s_tdata[1];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - $bits(res_t)){1'b0}}, out_q};

endmodule

// File: rtl/brc_cfg.sv
// Configuration register file for the recovery block.
// Depends on brc_pkg for register indexes and the cfg_t struct.
module brc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [brc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [brc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output brc_pkg::cfg_t                   cfg
);
	import brc_pkg::*;

	cfg_t cfg_q;

	// Register writes, one index per write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_mask     <= 2'd3;
			cfg_q.max_attempts    <= 4'd3;
			cfg_q.bump_reverse_ms <= 16'd2000;
			cfg_q.bump_rotate_ms  <= 16'd1000;
			cfg_q.edge_reverse_ms <= 16'd2000;
			cfg_q.edge_rotate_ms  <= 16'd1000;
			cfg_q.back_speed      <= 15'd2048;
			cfg_q.turn_speed      <= 15'd4096;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ENABLE_MASK:     cfg_q.enable_mask     <= cfg_wdata[1:0];
				REG_MAX_ATTEMPTS:    cfg_q.max_attempts    <= cfg_wdata[3:0];
				REG_BUMP_REVERSE_MS: cfg_q.bump_reverse_ms <= cfg_wdata;
				REG_BUMP_ROTATE_MS:  cfg_q.bump_rotate_ms  <= cfg_wdata;
				REG_EDGE_REVERSE_MS: cfg_q.edge_reverse_ms <= cfg_wdata;
				REG_EDGE_ROTATE_MS:  cfg_q.edge_rotate_ms  <= cfg_wdata;
				REG_BACK_SPEED:      cfg_q.back_speed      <= cfg_wdata[14:0];
				REG_TURN_SPEED:      cfg_q.turn_speed      <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/brc_core.sv
// Recovery state machine: channel flags, attempt counters, maneuver timer.
// Computes the result for the word in the input stage; state moves on adv.
// Depends on brc_pkg.
module brc_core #(
	parameter int TIMER_BITS = brc_pkg::TIMER_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic [1:0]     cmd,
	input  logic           left_flag,
	input  logic           right_flag,
	input  brc_pkg::cfg_t  cfg,
	output brc_pkg::res_t  res
);
	import brc_pkg::*;

	localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	// Saturate a 16-bit duration to the timer range
	function automatic logic [TIMER_BITS-1:0] clamp_time(input logic [15:0] ms);
		logic [CW-1:0] ms_w;
		logic [CW-1:0] max_w;
		ms_w  = CW'(ms);
		max_w = CW'({TIMER_BITS{1'b1}});
		return (ms_w > max_w) ? max_w[TIMER_BITS-1:0] : ms_w[TIMER_BITS-1:0];
	endfunction

	// State registers
	logic                  bump_pending_q, bump_start_left_q, bump_now_left_q, bump_now_right_q;
	logic [3:0]            bump_tries_q;
	logic                  edge_pending_q, edge_start_left_q, edge_out_left_q, edge_out_right_q;
	logic [3:0]            edge_tries_q;
	phase_t                phase_q;
	logic                  active_channel_q;
	logic [TIMER_BITS-1:0] time_left_q;
	logic                  turn_negative_q;

	// Next state
	logic                  bump_pending_d, bump_start_left_d, bump_now_left_d, bump_now_right_d;
	logic [3:0]            bump_tries_d;
	logic                  edge_pending_d, edge_start_left_d, edge_out_left_d, edge_out_right_d;
	logic [3:0]            edge_tries_d;
	phase_t                phase_d;
	logic                  active_channel_d;
	logic [TIMER_BITS-1:0] time_left_d;
	logic                  turn_negative_d;

	// Decisions handed to the output logic
	logic   emit;        // drive command this word
	logic   estop;       // attempts exhausted
	phase_t emit_phase;  // phase the drive command belongs to

	// Next state and decisions
	always_comb begin
		logic       serve;
		logic       sch;
		logic       stuck;
		logic [3:0] tries;
		logic       run;
		logic       fin;

		bump_pending_d    = bump_pending_q;
		bump_start_left_d = bump_start_left_q;
		bump_now_left_d   = bump_now_left_q;
		bump_now_right_d  = bump_now_right_q;
		bump_tries_d      = bump_tries_q;
		edge_pending_d    = edge_pending_q;
		edge_start_left_d = edge_start_left_q;
		edge_out_left_d   = edge_out_left_q;
		edge_out_right_d  = edge_out_right_q;
		edge_tries_d      = edge_tries_q;
		phase_d           = phase_q;
		active_channel_d  = active_channel_q;
		time_left_d       = time_left_q;
		turn_negative_d   = turn_negative_q;
		emit       = 1'b0;
		estop      = 1'b0;
		emit_phase = phase_q;
		serve = 1'b0;
		sch   = 1'b0;
		stuck = 1'b0;
		tries = 4'd0;
		run   = 1'b0;
		fin   = 1'b0;

		case (cmd)
			CMD_BUMP: begin
				if (!bump_pending_q && (left_flag || right_flag)) begin
					bump_pending_d    = 1'b1;
					bump_start_left_d = left_flag;
				end
				bump_now_left_d  = left_flag;
				bump_now_right_d = right_flag;
			end
			CMD_EDGE: begin
				// perimeter flags report inside; latch on outside
				if (!edge_pending_q && (!left_flag || !right_flag)) begin
					edge_pending_d    = 1'b1;
					edge_start_left_d = !left_flag;
				end
				edge_out_left_d  = !left_flag;
				edge_out_right_d = !right_flag;
			end
			CMD_TICK: begin
				if (phase_q == PH_REVERSE || phase_q == PH_ROTATE) begin
					run = 1'b1;
				end else begin
					phase_d = PH_IDLE;
					// bumper channel has priority
					if (cfg.enable_mask[0] && bump_pending_q) begin
						serve = 1'b1;
						sch   = 1'b0;
					end else if (cfg.enable_mask[1] && edge_pending_q) begin
						serve = 1'b1;
						sch   = 1'b1;
					end
					if (serve) begin
						active_channel_d = sch;
						stuck = sch ? (edge_out_left_q || edge_out_right_q)
						            : (bump_now_left_q || bump_now_right_q);
						tries = sch ? edge_tries_q : bump_tries_q;
						if (stuck && (tries >= cfg.max_attempts)) begin
							estop = 1'b1;
						end else if (stuck) begin
							phase_d     = PH_REVERSE;
							time_left_d = clamp_time(sch ? cfg.edge_reverse_ms
							                             : cfg.bump_reverse_ms);
							run = 1'b1;
						end else begin
							phase_d         = PH_ROTATE;
							turn_negative_d = sch ? edge_start_left_q : bump_start_left_q;
							time_left_d     = clamp_time(sch ? cfg.edge_rotate_ms
							                                 : cfg.bump_rotate_ms);
							run = 1'b1;
						end
					end
				end

				// One timer step; zero duration completes without driving
				if (run) begin
					emit_phase = phase_d;
					if (time_left_d == '0) begin
						fin = 1'b1;
					end else begin
						emit        = 1'b1;
						time_left_d = time_left_d - TIMER_BITS'(1);
						fin         = (time_left_d == '0);
					end
				end

				// Completion: count an attempt or clear the channel
				if (fin) begin
					if (phase_d == PH_REVERSE) begin
						if (!active_channel_d)
							bump_tries_d = bump_tries_q + 4'd1;
						else
							edge_tries_d = edge_tries_q + 4'd1;
					end else if (phase_d == PH_ROTATE) begin
						if (!active_channel_d) begin
							bump_tries_d      = 4'd0;
							bump_pending_d    = 1'b0;
							bump_start_left_d = 1'b0;
						end else begin
							edge_tries_d      = 4'd0;
							edge_pending_d    = 1'b0;
							edge_start_left_d = 1'b0;
						end
					end
					phase_d     = PH_IDLE;
					time_left_d = '0;
				end
			end
			default: ;
		endcase
	end

	// Result word
	always_comb begin
		res = '0;
		if (emit) begin
			res.drive_valid    = 1'b1;
			res.source_channel = active_channel_d;
			if (emit_phase == PH_REVERSE)
				res.linear_speed = 16'd0 - {1'b0, cfg.back_speed};
			else
				res.angular_speed = turn_negative_d ? (16'd0 - {1'b0, cfg.turn_speed})
				                                    : {1'b0, cfg.turn_speed};
		end else if (estop) begin
			res.drive_valid    = 1'b1;
			res.emergency_stop = 1'b1;
			res.source_channel = active_channel_d;
		end
	end

	// State update when the word moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bump_pending_q    <= 1'b0;
			bump_start_left_q <= 1'b0;
			bump_now_left_q   <= 1'b0;
			bump_now_right_q  <= 1'b0;
			bump_tries_q      <= 4'd0;
			edge_pending_q    <= 1'b0;
			edge_start_left_q <= 1'b0;
			edge_out_left_q   <= 1'b0;
			edge_out_right_q  <= 1'b0;
			edge_tries_q      <= 4'd0;
			phase_q           <= PH_IDLE;
			active_channel_q  <= 1'b0;
			time_left_q       <= '0;
			turn_negative_q   <= 1'b0;
		end else if (adv) begin
			bump_pending_q    <= bump_pending_d;
			bump_start_left_q <= bump_start_left_d;
			bump_now_left_q   <= bump_now_left_d;
			bump_now_right_q  <= bump_now_right_d;
			bump_tries_q      <= bump_tries_d;
			edge_pending_q    <= edge_pending_d;
			edge_start_left_q <= edge_start_left_d;
			edge_out_left_q   <= edge_out_left_d;
			edge_out_right_q  <= edge_out_right_d;
			edge_tries_q      <= edge_tries_d;
			phase_q           <= phase_d;
			active_channel_q  <= active_channel_d;
			time_left_q       <= time_left_d;
			turn_negative_q   <= turn_negative_d;
		end
	end

endmodule
